FILE: rtl/tafps_pkg.sv
package tafps_pkg;

	// Default values of the top level's parameters.
	localparam int DEF_FILTER_TAPS = 4;
	localparam int DEF_SAMPLE_BITS = 12;
	localparam int DEF_DRIVE_LIMIT = 200;
	localparam int DEF_SERVO_SWING = 25;

	// Fixed field widths.
	localparam int IN_W      = 12;
	localparam int SERVO_W   = 12;
	localparam int POS_W     = 14;
	localparam int ERR_W     = 15;
	localparam int FILT_W    = 24;
	localparam int COEF_W    = 20;
	localparam int TARGET_W  = 12;
	localparam int GAIN_W    = 16;
	localparam int CENTER_W  = 12;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	// Saturation bounds of the filter output (Q16.8) and of the position.
	localparam int FLT_MAX = 8388607;
	localparam int FLT_MIN = -8388608;
	localparam int POS_MAX = 8191;
	localparam int POS_MIN = -8192;
	localparam int SERVO_MAX = 4095;

	// Rounding offset applied before dropping 16 fraction bits.
	localparam int RND_HALF = 32768;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_X       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_X    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN_X   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_Y    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN_Y   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_CENTER_X = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_CENTER_Y = 4'd7;

	// Register values after reset.
	localparam logic [TARGET_W-1:0] RST_TARGET_X       = 12'd1600;
	localparam logic [TARGET_W-1:0] RST_TARGET_Y       = 12'd1520;
	localparam logic [GAIN_W-1:0]   RST_PROP_GAIN_X    = 16'd205;
	localparam logic [GAIN_W-1:0]   RST_DERIV_GAIN_X   = 16'd8192;
	localparam logic [GAIN_W-1:0]   RST_PROP_GAIN_Y    = 16'd123;
	localparam logic [GAIN_W-1:0]   RST_DERIV_GAIN_Y   = 16'd4096;
	localparam logic [CENTER_W-1:0] RST_SERVO_CENTER_X = 12'd3665;
	localparam logic [CENTER_W-1:0] RST_SERVO_CENTER_Y = 12'd3670;

	typedef struct packed {
		logic [TARGET_W-1:0] target;
		logic [GAIN_W-1:0]   kp;
		logic [GAIN_W-1:0]   kd;
		logic [CENTER_W-1:0] center;
	} axis_cfg_t;

	typedef struct packed {
		logic [SERVO_W-1:0]      servo;
		logic signed [POS_W-1:0] filtered;
	} lane_res_t;

	// Feed-forward coefficients of the Butterworth section, signed Q3.16.
	function automatic logic signed [COEF_W-1:0] coef_b(input logic [2:0] idx);
		logic signed [COEF_W-1:0] c;
		unique case (idx)
			3'd0:    c = 20'sd4388;
			3'd1:    c = 20'sd13164;
			3'd2:    c = 20'sd13164;
			3'd3:    c = 20'sd4388;
			default: c = '0;
		endcase
		return c;
	endfunction

	// Feedback coefficients, signed Q3.16. The leading one is implicit.
	function automatic logic signed [COEF_W-1:0] coef_a(input logic [2:0] idx);
		logic signed [COEF_W-1:0] c;
		unique case (idx)
			3'd1:    c = -20'sd60733;
			3'd2:    c = 20'sd36876;
			3'd3:    c = -20'sd6574;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/tafps_if.sv
interface tafps_in_if;
	logic                             valid;
	logic                             ready;
	logic [tafps_pkg::IN_W-1:0]       sample_x;
	logic [tafps_pkg::IN_W-1:0]       sample_y;

	modport source (output valid, output sample_x, output sample_y, input ready);
	modport sink (input valid, input sample_x, input sample_y, output ready);
endinterface

interface tafps_out_if;
	logic                                valid;
	logic                                ready;
	logic [tafps_pkg::SERVO_W-1:0]       servo_x;
	logic [tafps_pkg::SERVO_W-1:0]       servo_y;
	logic signed [tafps_pkg::POS_W-1:0]  filtered_x;
	logic signed [tafps_pkg::POS_W-1:0]  filtered_y;

	modport source (output valid, output servo_x, output servo_y, output filtered_x,
		output filtered_y, input ready);
	modport sink (input valid, input servo_x, input servo_y, input filtered_x,
		input filtered_y, output ready);
endinterface

interface tafps_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tafps_pkg::CFG_IDX_W-1:0]    index;
	logic [tafps_pkg::CFG_DAT_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tafps_lane.sv
module tafps_lane #(
	parameter int FILTER_TAPS = tafps_pkg::DEF_FILTER_TAPS,
	parameter int SAMPLE_BITS = tafps_pkg::DEF_SAMPLE_BITS,
	parameter int DRIVE_LIMIT = tafps_pkg::DEF_DRIVE_LIMIT,
	parameter int SERVO_SWING = tafps_pkg::DEF_SERVO_SWING
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  tafps_pkg::axis_cfg_t   cfg,
	input  logic                   ack,
	output logic                   done,
	output tafps_pkg::lane_res_t   res
);

	localparam int KW     = $clog2(FILTER_TAPS);
	localparam int FW     = tafps_pkg::FILT_W;
	localparam int CW     = tafps_pkg::COEF_W;
	localparam int PB_W   = CW + SAMPLE_BITS + 1;
	localparam int PA_W   = CW + FW;
	localparam int ACC_W  = ((PB_W + 8 > PA_W) ? PB_W + 8 : PA_W) + 5;
	localparam int PW     = tafps_pkg::POS_W;
	localparam int EW     = tafps_pkg::ERR_W;
	localparam int GW     = tafps_pkg::GAIN_W;
	localparam int PK_W   = GW + 1 + EW;
	localparam int DK_W   = GW + 1 + EW + 1;
	localparam int SUM_W  = DK_W + 2;
	localparam int DRV_W  = $clog2(DRIVE_LIMIT + 1) + 1;
	localparam int SV_W   = tafps_pkg::SERVO_W + 2;
	localparam int DCL_W  = 13;
	localparam logic signed [SUM_W-1:0] DL_S = SUM_W'(DRIVE_LIMIT);
	localparam logic signed [DCL_W-1:0] SW_S = DCL_W'(SERVO_SWING);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MAC   = 10'b0000000010,
		ST_DRAIN = 10'b0000000100,
		ST_FILT  = 10'b0000001000,
		ST_POSN  = 10'b0000010000,
		ST_PDMUL = 10'b0000100000,
		ST_PDSUM = 10'b0001000000,
		ST_DRIVE = 10'b0010000000,
		ST_SERVO = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [KW-1:0] k_q;
	logic prod_vld_q;

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] raw_hist_q [1:FILTER_TAPS-1];
	logic signed [FW-1:0] flt_hist_q [1:FILTER_TAPS-1];
	logic signed [EW-1:0] last_e_q;

	logic signed [PB_W-1:0] prod_b_q;
	logic signed [PA_W-1:0] prod_a_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [FW-1:0] y_q;
	logic signed [PW-1:0] pos_q;
	logic signed [EW-1:0] e_q;
	logic signed [EW:0] de_q;
	logic signed [PK_W-1:0] pk_q;
	logic signed [DK_W-1:0] dk_q;
	logic signed [SUM_W-1:0] neg_q;
	logic signed [DRV_W-1:0] drive_q;
	logic [tafps_pkg::SERVO_W-1:0] servo_q;

	logic [SAMPLE_BITS-1:0] raw_sel;
	logic signed [FW-1:0] flt_sel;
	logic k_last;
	logic signed [ACC_W-1:0] acc_rnd, acc_sh;
	logic signed [FW-1:0] y_sat;
	logic signed [15:0] y_div;
	logic signed [PW-1:0] pos_c;
	logic signed [EW-1:0] e_c;
	logic signed [SUM_W-1:0] q_div;
	logic signed [DRV_W-1:0] drive_c;
	logic signed [DCL_W-1:0] d13, dcl;
	logic signed [SV_W-1:0] sv;
	logic [tafps_pkg::SERVO_W-1:0] servo_c;

	assign k_last = (k_q == KW'(FILTER_TAPS - 1));

	// Tap zero is the new sample; its feedback term has no coefficient.
	always_comb begin
		raw_sel = sample_q;
		flt_sel = '0;
		for (int i = 1; i < FILTER_TAPS; i++) begin
			if (k_q == KW'(i)) begin
				raw_sel = raw_hist_q[i];
				flt_sel = flt_hist_q[i];
			end
		end
	end

	always_comb begin
		acc_rnd = acc_q + ACC_W'(tafps_pkg::RND_HALF);
		acc_sh = acc_rnd >>> 16;
		if (acc_sh > ACC_W'(tafps_pkg::FLT_MAX)) begin
			y_sat = FW'(tafps_pkg::FLT_MAX);
		end else if (acc_sh < ACC_W'(tafps_pkg::FLT_MIN)) begin
			y_sat = FW'(tafps_pkg::FLT_MIN);
		end else begin
			y_sat = acc_sh[FW-1:0];
		end
	end

	// Position is the Q16.8 output divided by 256, rounded toward zero.
	always_comb begin
		y_div = $signed(y_q[FW-1:8]) + $signed({15'b0, (y_q[FW-1] && (y_q[7:0] != '0))});
		if (y_div > 16'(tafps_pkg::POS_MAX)) begin
			pos_c = PW'(tafps_pkg::POS_MAX);
		end else if (y_div < 16'(tafps_pkg::POS_MIN)) begin
			pos_c = PW'(tafps_pkg::POS_MIN);
		end else begin
			pos_c = y_div[PW-1:0];
		end
		e_c = EW'(pos_c) - $signed({3'b0, cfg.target});
	end

	always_comb begin
		q_div = (neg_q >>> 12) + $signed({{(SUM_W-1){1'b0}}, (neg_q[SUM_W-1] && (neg_q[11:0] != '0))});
		if (q_div > DL_S) begin
			drive_c = DRV_W'(DRIVE_LIMIT);
		end else if (q_div < -DL_S) begin
			drive_c = -DRV_W'(DRIVE_LIMIT);
		end else begin
			drive_c = q_div[DRV_W-1:0];
		end
	end

	always_comb begin
		d13 = DCL_W'(drive_q);
		if (d13 > SW_S) begin
			dcl = SW_S;
		end else if (d13 < -SW_S) begin
			dcl = -SW_S;
		end else begin
			dcl = d13;
		end
		sv = $signed({2'b0, cfg.center}) - SV_W'(dcl);
		if (sv < 0) begin
			servo_c = '0;
		end else if (sv > SV_W'(tafps_pkg::SERVO_MAX)) begin
			servo_c = tafps_pkg::SERVO_W'(tafps_pkg::SERVO_MAX);
		end else begin
			servo_c = sv[tafps_pkg::SERVO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			prod_vld_q <= 1'b0;
			last_e_q <= '0;
			for (int i = 1; i < FILTER_TAPS; i++) begin
				raw_hist_q[i] <= '0;
				flt_hist_q[i] <= '0;
			end
		end else begin
			prod_vld_q <= (state_q == ST_MAC);
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (start) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					k_q <= k_q + KW'(1);
					if (k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FILT;
				ST_FILT: begin
					raw_hist_q[1] <= sample_q;
					flt_hist_q[1] <= y_sat;
					for (int i = 2; i < FILTER_TAPS; i++) begin
						raw_hist_q[i] <= raw_hist_q[i-1];
						flt_hist_q[i] <= flt_hist_q[i-1];
					end
					state_q <= ST_POSN;
				end
				ST_POSN: begin
					last_e_q <= e_c;
					state_q <= ST_PDMUL;
				end
				ST_PDMUL: state_q <= ST_PDSUM;
				ST_PDSUM: state_q <= ST_DRIVE;
				ST_DRIVE: state_q <= ST_SERVO;
				ST_SERVO: state_q <= ST_DONE;
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			sample_q <= sample;
			acc_q <= '0;
		end else if (prod_vld_q) begin
			acc_q <= acc_q + (ACC_W'(prod_b_q) <<< 8) - ACC_W'(prod_a_q);
		end
		prod_b_q <= tafps_pkg::coef_b(3'(k_q)) * $signed({1'b0, raw_sel});
		prod_a_q <= tafps_pkg::coef_a(3'(k_q)) * flt_sel;
		if (state_q == ST_FILT) begin
			y_q <= y_sat;
		end
		if (state_q == ST_POSN) begin
			pos_q <= pos_c;
			e_q <= e_c;
			de_q <= (EW+1)'(e_c) - (EW+1)'(last_e_q);
		end
		if (state_q == ST_PDMUL) begin
			pk_q <= $signed({1'b0, cfg.kp}) * e_q;
			dk_q <= $signed({1'b0, cfg.kd}) * de_q;
		end
		if (state_q == ST_PDSUM) begin
			neg_q <= -SUM_W'(pk_q) - SUM_W'(dk_q);
		end
		if (state_q == ST_DRIVE) begin
			drive_q <= drive_c;
		end
		if (state_q == ST_SERVO) begin
			servo_q <= servo_c;
		end
	end

	assign done = (state_q == ST_DONE);
	assign res.servo = servo_q;
	assign res.filtered = pos_q;

endmodule

FILE: rtl/two_axis_filtered_pd_servo_control.sv
// Two-axis servo controller: a third-order Butterworth low-pass filter and a
// PD law per axis, one lane for X and one for Y working side by side.
// sample_in carries one beat of X and Y samples; result_out returns one beat
// with both servo compare values and both filtered positions. cfg writes the
// setpoints, gains and servo centers; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// The filter taps go through one multiply pair per lane per cycle, followed
// by a fixed chain of seven steps for rounding, the PD products, clamping and
// the servo value. One item is in the lanes at a time: a new sample is taken
// only once the lanes have handed the last result to the output register. The
// result waits there while a new sample is accepted, but if the receiver still
// stalls when the next result is done, the finished lanes hold until the
// register frees.
// Reset clears the filter histories, the previous errors and the handshake
// state, and loads the registers with their default values.
module two_axis_filtered_pd_servo_control #(
	parameter int FILTER_TAPS = tafps_pkg::DEF_FILTER_TAPS,
	parameter int SAMPLE_BITS = tafps_pkg::DEF_SAMPLE_BITS,
	parameter int DRIVE_LIMIT = tafps_pkg::DEF_DRIVE_LIMIT,
	parameter int SERVO_SWING = tafps_pkg::DEF_SERVO_SWING
) (
	input  logic        clk,
	input  logic        arst_n,
	tafps_in_if.sink    sample_in,
	tafps_out_if.source result_out,
	tafps_cfg_if.sink   cfg
);

	logic [tafps_pkg::TARGET_W-1:0] target_x_q, target_y_q;
	logic [tafps_pkg::GAIN_W-1:0]   kp_x_q, kd_x_q, kp_y_q, kd_y_q;
	logic [tafps_pkg::CENTER_W-1:0] center_x_q, center_y_q;

	tafps_pkg::axis_cfg_t cfg_x, cfg_y;
	tafps_pkg::lane_res_t res_x, res_y;

	logic busy_q;
	logic out_vld_q;
	logic start;
	logic done_x, done_y;
	logic load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= tafps_pkg::RST_TARGET_X;
			target_y_q <= tafps_pkg::RST_TARGET_Y;
			kp_x_q <= tafps_pkg::RST_PROP_GAIN_X;
			kd_x_q <= tafps_pkg::RST_DERIV_GAIN_X;
			kp_y_q <= tafps_pkg::RST_PROP_GAIN_Y;
			kd_y_q <= tafps_pkg::RST_DERIV_GAIN_Y;
			center_x_q <= tafps_pkg::RST_SERVO_CENTER_X;
			center_y_q <= tafps_pkg::RST_SERVO_CENTER_Y;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tafps_pkg::REG_TARGET_X:       target_x_q <= cfg.data[tafps_pkg::TARGET_W-1:0];
				tafps_pkg::REG_TARGET_Y:       target_y_q <= cfg.data[tafps_pkg::TARGET_W-1:0];
				tafps_pkg::REG_PROP_GAIN_X:    kp_x_q <= cfg.data;
				tafps_pkg::REG_DERIV_GAIN_X:   kd_x_q <= cfg.data;
				tafps_pkg::REG_PROP_GAIN_Y:    kp_y_q <= cfg.data;
				tafps_pkg::REG_DERIV_GAIN_Y:   kd_y_q <= cfg.data;
				tafps_pkg::REG_SERVO_CENTER_X: center_x_q <= cfg.data[tafps_pkg::CENTER_W-1:0];
				tafps_pkg::REG_SERVO_CENTER_Y: center_y_q <= cfg.data[tafps_pkg::CENTER_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_x = '{target: target_x_q, kp: kp_x_q, kd: kd_x_q, center: center_x_q};
	assign cfg_y = '{target: target_y_q, kp: kp_y_q, kd: kd_y_q, center: center_y_q};

	assign sample_in.ready = !busy_q;
	assign start = sample_in.valid && !busy_q;

	tafps_lane #(
		.FILTER_TAPS(FILTER_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.DRIVE_LIMIT(DRIVE_LIMIT),
		.SERVO_SWING(SERVO_SWING)
	) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sample (SAMPLE_BITS'(sample_in.sample_x)),
		.cfg    (cfg_x),
		.ack    (load),
		.done   (done_x),
		.res    (res_x)
	);

	tafps_lane #(
		.FILTER_TAPS(FILTER_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.DRIVE_LIMIT(DRIVE_LIMIT),
		.SERVO_SWING(SERVO_SWING)
	) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sample (SAMPLE_BITS'(sample_in.sample_y)),
		.cfg    (cfg_y),
		.ack    (load),
		.done   (done_y),
		.res    (res_y)
	);

	// Both lanes run in lockstep; the merge waits for both and a free output slot.
	assign load = done_x && done_y && (!out_vld_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (result_out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_out.servo_x <= res_x.servo;
			result_out.servo_y <= res_y.servo;
			result_out.filtered_x <= res_x.filtered;
			result_out.filtered_y <= res_y.filtered;
		end
	end

	assign result_out.valid = out_vld_q;

endmodule
